### rtl/atpr_pkg.sv
// Shared widths, CORDIC vector type, arctangent table and output rounding for the tilt block.
package atpr_pkg;

  localparam int CORDIC_STAGES = 14;

  localparam int IN_W     = 16;
  localparam int OUT_W    = 15;
  localparam int SCALE_SH = 14;
  localparam int VEC_W    = 34;
  localparam int ANG_W    = 24;
  localparam int SHIFT_W  = 5;
  localparam int ROUND_SH = 7;
  localparam int ROUND_HALF  = 64;
  localparam int ANGLE_LIMIT = 12868;

  localparam int LANES_A = 4;
  localparam int LANES_B = 2;

  // first pass lanes: magnitude and numerator for each angle
  localparam int LANE_MAG_P = 0;
  localparam int LANE_NUM_P = 1;
  localparam int LANE_MAG_R = 2;
  localparam int LANE_NUM_R = 3;
  // second pass lanes
  localparam int LANE_P = 0;
  localparam int LANE_R = 1;

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [ANG_W-1:0] z;
  } vec_t;

  // atan(2^-i) in Q20
  function automatic logic signed [ANG_W-1:0] atan_q20(input logic [SHIFT_W-1:0] idx);
    logic signed [ANG_W-1:0] r;
    unique case (idx)
      5'd0:  r = ANG_W'(823550);
      5'd1:  r = ANG_W'(486170);
      5'd2:  r = ANG_W'(256879);
      5'd3:  r = ANG_W'(130396);
      5'd4:  r = ANG_W'(65451);
      5'd5:  r = ANG_W'(32757);
      5'd6:  r = ANG_W'(16383);
      5'd7:  r = ANG_W'(8192);
      5'd8:  r = ANG_W'(4096);
      5'd9:  r = ANG_W'(2048);
      5'd10: r = ANG_W'(1024);
      5'd11: r = ANG_W'(512);
      5'd12: r = ANG_W'(256);
      5'd13: r = ANG_W'(128);
      5'd14: r = ANG_W'(64);
      5'd15: r = ANG_W'(32);
      5'd16: r = ANG_W'(16);
      5'd17: r = ANG_W'(8);
      5'd18: r = ANG_W'(4);
      5'd19: r = ANG_W'(2);
      5'd20: r = ANG_W'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

  // |a| * 2^14, zero extended to vector width
  function automatic logic signed [VEC_W-1:0] scale_abs(input logic signed [IN_W-1:0] a);
    logic signed [IN_W:0] e;
    logic        [IN_W:0] m;
    e = {a[IN_W-1], a};
    m = e[IN_W] ? (-e) : e;
    return {{(VEC_W-IN_W-1-SCALE_SH){1'b0}}, m, {SCALE_SH{1'b0}}};
  endfunction

  // Q20 -> Q13 round half up, clamp to +-pi/2
  function automatic logic signed [OUT_W-1:0] round_clamp(input logic signed [ANG_W-1:0] ang);
    logic signed [ANG_W-1:0] q;
    logic signed [ANG_W-1:0] lim;
    q   = (ang + $signed(ANG_W'(ROUND_HALF))) >>> ROUND_SH;
    lim = $signed(ANG_W'(ANGLE_LIMIT));
    if (q > lim) begin
      q = lim;
    end else if (q < -lim) begin
      q = -lim;
    end
    return q[OUT_W-1:0];
  endfunction

endpackage

### rtl/accel_tilt_pitch_roll_top.sv
// Top level: pitch and roll from one accelerometer sample through two CORDIC cell chains.
//
//   channel  valid         stall         payload
//   sample   sample_valid  sample_stall  accel_x, accel_y, accel_z
//   angle    angle_valid   angle_stall   pitch_angle, roll_angle
//
// One item per cycle while the angle channel does not stall; each item passes the first chain,
// the join register, the second chain and the output register.
// Reset clears only the valid bits of the chains, the join register and the output register.
// The chains shift while the last stage of the second chain is empty or the output register is free,
// so a waiting result blocks new samples once an item reaches that stage.
module accel_tilt_pitch_roll_top import atpr_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic signed [IN_W-1:0]  accel_x,
  input  logic signed [IN_W-1:0]  accel_y,
  input  logic signed [IN_W-1:0]  accel_z,
  input  logic                    sample_valid,
  output logic                    sample_stall,
  output logic signed [OUT_W-1:0] pitch_angle,
  output logic signed [OUT_W-1:0] roll_angle,
  output logic                    angle_valid,
  input  logic                    angle_stall
);

  localparam int LAST = CORDIC_STAGES - 1;

  vec_t a_src [LANES_A];
  vec_t a_q   [CORDIC_STAGES][LANES_A];
  vec_t j_vec [LANES_B];
  vec_t b_q   [CORDIC_STAGES][LANES_B];
  vec_t j_next [LANES_B];

  logic [CORDIC_STAGES-1:0] a_valid;
  logic [CORDIC_STAGES-1:0] b_valid;
  logic                     j_valid;
  logic [LANES_B-1:0]       a_sign [CORDIC_STAGES];
  logic [LANES_B-1:0]       b_zero [CORDIC_STAGES];
  logic [LANES_B-1:0]       j_zero;
  logic [LANES_B-1:0]       j_zero_next;

  logic en;
  logic out_free;

  assign out_free     = !angle_valid || !angle_stall;
  assign en           = !b_valid[LAST] || out_free;
  assign sample_stall = !en;

  always_comb begin
    a_src[LANE_MAG_P] = '{x: scale_abs(accel_y), y: scale_abs(accel_z), z: '0};
    a_src[LANE_NUM_P] = '{x: scale_abs(accel_x), y: '0, z: '0};
    a_src[LANE_MAG_R] = '{x: scale_abs(accel_x), y: scale_abs(accel_z), z: '0};
    a_src[LANE_NUM_R] = '{x: scale_abs(accel_y), y: '0, z: '0};
  end

  // first chain: magnitudes and gained numerators
  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_a
    for (genvar l = 0; l < LANES_A; l++) begin : g_lane
      atpr_cell u_cell (
        .clk       (clk),
        .en        (en),
        .shift     (SHIFT_W'(k)),
        .atan_step (atan_q20(SHIFT_W'(k))),
        .d         ((k == 0) ? a_src[l] : a_q[(k == 0) ? 0 : k-1][l]),
        .q         (a_q[k][l])
      );
    end
  end

  // join: restore numerator sign, flag the all-zero case
  always_comb begin
    for (int l = 0; l < LANES_B; l++) begin
      j_next[l].x = a_q[LAST][2*l].x;
      j_next[l].y = a_sign[LAST][l] ? -a_q[LAST][2*l+1].x : a_q[LAST][2*l+1].x;
      j_next[l].z = '0;
      j_zero_next[l] = (a_q[LAST][2*l].x == '0) && (a_q[LAST][2*l+1].x == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      j_vec  <= j_next;
      j_zero <= j_zero_next;
      a_sign[0] <= {accel_y[IN_W-1], accel_x[IN_W-1]};
      b_zero[0] <= j_zero;
      for (int k = 1; k < CORDIC_STAGES; k++) begin
        a_sign[k] <= a_sign[k-1];
        b_zero[k] <= b_zero[k-1];
      end
    end
  end

  // second chain: angles
  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_b
    for (genvar l = 0; l < LANES_B; l++) begin : g_lane
      atpr_cell u_cell (
        .clk       (clk),
        .en        (en),
        .shift     (SHIFT_W'(k)),
        .atan_step (atan_q20(SHIFT_W'(k))),
        .d         ((k == 0) ? j_vec[l] : b_q[(k == 0) ? 0 : k-1][l]),
        .q         (b_q[k][l])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid     <= '0;
      j_valid     <= 1'b0;
      b_valid     <= '0;
      angle_valid <= 1'b0;
    end else begin
      if (en) begin
        a_valid <= {a_valid[CORDIC_STAGES-2:0], sample_valid};
        j_valid <= a_valid[LAST];
        b_valid <= {b_valid[CORDIC_STAGES-2:0], j_valid};
      end
      if (out_free) begin
        angle_valid <= b_valid[LAST];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && b_valid[LAST]) begin
      pitch_angle <= b_zero[LAST][LANE_P] ? '0 : round_clamp(b_q[LAST][LANE_P].z);
      roll_angle  <= b_zero[LAST][LANE_R] ? '0 : round_clamp(b_q[LAST][LANE_R].z);
    end
  end

  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    angle_valid |-> (pitch_angle <= ANGLE_LIMIT) && (pitch_angle >= -ANGLE_LIMIT))
    else $error("pitch out of range");

  a_roll_range: assert property (@(posedge clk) disable iff (rst)
    angle_valid |-> (roll_angle <= ANGLE_LIMIT) && (roll_angle >= -ANGLE_LIMIT))
    else $error("roll out of range");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_stall |=> a_valid[0])
    else $error("accepted item missing from first stage");

  a_full_blocks: assert property (@(posedge clk) disable iff (rst)
    b_valid[LAST] && angle_valid && angle_stall |-> sample_stall)
    else $error("chain moved while full and output stalled");

endmodule

### rtl/atpr_cell.sv
// One CORDIC vectoring micro-rotation with its output register.
module atpr_cell import atpr_pkg::*; (
  input  logic                    clk,
  input  logic                    en,
  input  logic [SHIFT_W-1:0]      shift,
  input  logic signed [ANG_W-1:0] atan_step,
  input  vec_t                    d,
  output vec_t                    q
);

  logic signed [VEC_W-1:0] dx;
  logic signed [VEC_W-1:0] dy;
  vec_t                    q_next;

  always_comb begin
    dx = d.y >>> shift;
    dy = d.x >>> shift;
    if (!d.y[VEC_W-1]) begin
      q_next.x = d.x + dx;
      q_next.y = d.y - dy;
      q_next.z = d.z + atan_step;
    end else begin
      q_next.x = d.x - dx;
      q_next.y = d.y + dy;
      q_next.z = d.z - atan_step;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= q_next;
    end
  end

endmodule
